### rtl/core/hcle_pkg.sv
// Shared constants, types and the header-name table of the Content-Length extractor.
`timescale 1ns / 1ps

package hcle_pkg;

    // Default width of the parsed length
    localparam int LENGTH_WIDTH_DEF = 64;

    // Width of the length field on the result stream
    localparam int LEN_OUT_W = 64;

    // Header name that is matched, and its length
    localparam int KEY_LEN = 14;
    localparam int KEY_POS_W = 4;

    // Control characters
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HT = 8'h09;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_UP_Z = 8'h5A;

    // One result per message
    typedef struct packed {
        logic                 length_found;
        logic [LEN_OUT_W-1:0] length_value;
        logic                 ended_at_blank_line;
    } hcle_result_t;

    // Lower-case "content-length", one character per position
    function automatic logic [7:0] key_char(input logic [KEY_POS_W-1:0] idx);
        logic [7:0] ch;
        begin
            unique case (idx)
                4'd0:    ch = 8'h63; // c
                4'd1:    ch = 8'h6F; // o
                4'd2:    ch = 8'h6E; // n
                4'd3:    ch = 8'h74; // t
                4'd4:    ch = 8'h65; // e
                4'd5:    ch = 8'h6E; // n
                4'd6:    ch = 8'h74; // t
                4'd7:    ch = 8'h2D; // -
                4'd8:    ch = 8'h6C; // l
                4'd9:    ch = 8'h65; // e
                4'd10:   ch = 8'h6E; // n
                4'd11:   ch = 8'h67; // g
                4'd12:   ch = 8'h74; // t
                4'd13:   ch = 8'h68; // h
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

### rtl/core/hcle_parser.sv
// Per-byte header parser: line state, value accumulator and best length.
`timescale 1ns / 1ps

module hcle_parser #(
    parameter int LENGTH_WIDTH = hcle_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_message,
    output logic                  res_valid,
    output hcle_pkg::hcle_result_t res
);

    // Line phase codes
    localparam logic [2:0] PH_NAME   = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_WS     = 3'd2;
    localparam logic [2:0] PH_SIGN   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    typedef struct packed {
        logic                                  nonempty;
        logic [2:0]                            phase;
        logic [hcle_pkg::KEY_POS_W-1:0]        pos;
        logic                                  mismatch;
        logic                                  negative;
        logic                                  seen;
        logic                                  overflow;
        logic [LENGTH_WIDTH-1:0]               acc;
    } line_t;

    localparam line_t LINE_CLEAR = '{
        nonempty: 1'b0, phase: PH_NAME, pos: '0, mismatch: 1'b0,
        negative: 1'b0, seen: 1'b0, overflow: 1'b0, acc: '0
    };

    // Feeding a CR: whitespace in the value, a mismatch in the name
    function automatic line_t feed_cr(input line_t l, input logic first);
        line_t r;
        begin
            r = l;
            r.nonempty = 1'b1;
            if (!first)
            begin
                if (l.phase == PH_NAME)
                begin
                    r.mismatch = 1'b1;
                end
                else if (l.phase == PH_SIGN || l.phase == PH_DIGITS)
                begin
                    r.phase = PH_DONE;
                end
            end
            return r;
        end
    endfunction

    // Feeding one ordinary byte
    function automatic line_t feed_byte(input line_t l, input logic first,
                                        input logic [7:0] c);
        line_t                 r;
        logic [7:0]            lc;
        logic                  is_dig;
        logic                  is_sp;
        logic                  add;
        logic [LENGTH_WIDTH+3:0] wide;
        begin
            r = l;
            r.nonempty = 1'b1;
            lc = (c >= hcle_pkg::CHAR_UP_A && c <= hcle_pkg::CHAR_UP_Z) ? (c + 8'd32) : c;
            is_dig = (c >= hcle_pkg::CHAR_ZERO) && (c <= hcle_pkg::CHAR_NINE);
            is_sp = (c == hcle_pkg::CHAR_SPACE) ||
                    (c >= hcle_pkg::CHAR_HT && c <= hcle_pkg::CHAR_CR);
            add = 1'b0;
            // acc * 10 + digit, checked against the length width
            wide = ({4'b0000, l.acc} << 3) + ({4'b0000, l.acc} << 1)
                 + {{LENGTH_WIDTH{1'b0}}, c[3:0]};
            if (!first)
            begin
                unique case (l.phase)
                    PH_NAME:
                    begin
                        if (c == hcle_pkg::CHAR_COLON)
                        begin
                            r.phase = (!l.mismatch &&
                                       l.pos == hcle_pkg::KEY_POS_W'(hcle_pkg::KEY_LEN))
                                      ? PH_WS : PH_SKIP;
                        end
                        else if (l.pos < hcle_pkg::KEY_POS_W'(hcle_pkg::KEY_LEN) &&
                                 lc == hcle_pkg::key_char(l.pos))
                        begin
                            r.pos = l.pos + 1'b1;
                        end
                        else
                        begin
                            r.mismatch = 1'b1;
                        end
                    end
                    PH_WS:
                    begin
                        if (is_sp)
                        begin
                            r.phase = PH_WS;
                        end
                        else if (c == hcle_pkg::CHAR_PLUS)
                        begin
                            r.phase = PH_SIGN;
                        end
                        else if (c == hcle_pkg::CHAR_MINUS)
                        begin
                            r.negative = 1'b1;
                            r.phase = PH_SIGN;
                        end
                        else if (is_dig)
                        begin
                            r.phase = PH_DIGITS;
                            add = 1'b1;
                        end
                        else
                        begin
                            r.phase = PH_DONE;
                        end
                    end
                    PH_SIGN, PH_DIGITS:
                    begin
                        if (is_dig)
                        begin
                            r.phase = PH_DIGITS;
                            add = 1'b1;
                        end
                        else
                        begin
                            r.phase = PH_DONE;
                        end
                    end
                    default:
                    begin
                        r.phase = l.phase;
                    end
                endcase
            end
            // Digit accumulate; overflow freezes the magnitude
            if (add)
            begin
                r.seen = 1'b1;
                if (!l.overflow)
                begin
                    if (|wide[LENGTH_WIDTH+3:LENGTH_WIDTH])
                    begin
                        r.overflow = 1'b1;
                    end
                    else
                    begin
                        r.acc = wide[LENGTH_WIDTH-1:0];
                    end
                end
            end
            return r;
        end
    endfunction

    function automatic logic value_ok(input line_t l);
        return (l.phase == PH_DIGITS || l.phase == PH_DONE) && l.seen && !l.overflow;
    endfunction

    function automatic logic [LENGTH_WIDTH-1:0] line_value(input line_t l);
        return l.negative ? (~l.acc + 1'b1) : l.acc;
    endfunction

    line_t                   line_reg, line_next;
    logic                    first_reg, first_next;
    logic                    hdone_reg, hdone_next;
    logic                    pend_reg, pend_next;
    logic                    bfound_reg, bfound_next;
    logic [LENGTH_WIDTH-1:0] blen_reg, blen_next;
    logic                    emit;
    logic                    emit_blank;
    logic                    clr;
    logic                    blank;
    logic [hcle_pkg::LEN_OUT_W-1:0] value_ext;

    // Next state for one byte
    always_comb
    begin
        line_next = line_reg;
        first_next = first_reg;
        hdone_next = hdone_reg;
        pend_next = pend_reg;
        bfound_next = bfound_reg;
        blen_next = blen_reg;
        emit = 1'b0;
        emit_blank = 1'b0;
        clr = 1'b0;
        blank = 1'b0;
        if (hdone_reg)
        begin
            // after the empty line: wait for the end of the message
            clr = end_of_message;
        end
        else if (pend_reg && data_byte == hcle_pkg::CHAR_LF)
        begin
            // CR LF closes the line
            pend_next = 1'b0;
            blank = !first_reg && !line_reg.nonempty;
            if (first_reg)
            begin
                first_next = 1'b0;
            end
            else if (!blank && value_ok(line_reg))
            begin
                blen_next = line_value(line_reg);
                bfound_next = 1'b1;
            end
            line_next = LINE_CLEAR;
            if (blank)
            begin
                emit = 1'b1;
                emit_blank = 1'b1;
                hdone_next = 1'b1;
                clr = end_of_message;
            end
            else if (end_of_message)
            begin
                emit = 1'b1;
                clr = 1'b1;
            end
        end
        else
        begin
            // held CR turns out to be an ordinary byte
            if (pend_reg)
            begin
                line_next = feed_cr(line_next, first_reg);
            end
            pend_next = (data_byte == hcle_pkg::CHAR_CR);
            if (data_byte != hcle_pkg::CHAR_CR)
            begin
                line_next = feed_byte(line_next, first_reg, data_byte);
            end
            if (end_of_message)
            begin
                if (data_byte == hcle_pkg::CHAR_CR)
                begin
                    line_next = feed_cr(line_next, first_reg);
                end
                if (!first_reg && line_next.nonempty && value_ok(line_next))
                begin
                    blen_next = line_value(line_next);
                    bfound_next = 1'b1;
                end
                emit = 1'b1;
                clr = 1'b1;
            end
        end
    end

    // Result as seen before the message state is cleared
    always_comb
    begin
        value_ext = '0;
        value_ext[LENGTH_WIDTH-1:0] = bfound_next ? blen_next : '0;
    end

    assign res_valid = step_en && emit;
    assign res.length_found = bfound_next;
    assign res.length_value = value_ext;
    assign res.ended_at_blank_line = emit_blank;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= LINE_CLEAR;
            first_reg <= 1'b1;
            hdone_reg <= 1'b0;
            pend_reg <= 1'b0;
            bfound_reg <= 1'b0;
            blen_reg <= '0;
        end
        else if (step_en)
        begin
            if (clr)
            begin
                line_reg <= LINE_CLEAR;
                first_reg <= 1'b1;
                hdone_reg <= 1'b0;
                pend_reg <= 1'b0;
                bfound_reg <= 1'b0;
                blen_reg <= '0;
            end
            else
            begin
                line_reg <= line_next;
                first_reg <= first_next;
                hdone_reg <= hdone_next;
                pend_reg <= pend_next;
                bfound_reg <= bfound_next;
                blen_reg <= blen_next;
            end
        end
    end

endmodule

### rtl/core/http_content_length_extractor_top.sv
// Top level of the HTTP Content-Length extractor: input skid stage, parser, result register.
//
//  Channel  Dir  Transfer on          Payload
//  s_*      in   s_tvalid & s_tready  tdata[7:0] data_byte, tlast end_of_message
//  m_*      out  m_tvalid & m_tready  tdata[63:0] length_value,
//                                     tuser[0] length_found, tuser[1] ended_at_blank_line
//
// One byte per cycle while m_tready does not stall; a byte waits in the input register
// until the parser steps; that edge also loads any result into the result register.
// rst_n (async, active low) returns the parser to the start of a message.
// s_tready is registered: a two-entry input stage absorbs a stall of m_tready.
// A stalled result holds the parser; bytes with no result still wait behind it.
`timescale 1ns / 1ps

module http_content_length_extractor_top #(
    parameter int LENGTH_WIDTH = hcle_pkg::LENGTH_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] length_value
    output logic [1:0]  m_tuser    // [0] length_found, [1] ended_at_blank_line
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_byte_reg;
    logic       skid_last_reg;
    logic       s_xfer;
    logic       advance;
    logic       res_valid;
    hcle_pkg::hcle_result_t res;
    logic       out_valid_reg;
    hcle_pkg::hcle_result_t out_reg;

    assign s_tready = !skid_valid_reg;
    assign s_xfer = s_tvalid && s_tready;
    assign advance = in_valid_reg && (!out_valid_reg || m_tready);

    // Input register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_valid_reg || advance)
            begin
                if (skid_valid_reg)
                begin
                    in_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    in_valid_reg <= s_xfer;
                end
            end
            else if (s_xfer)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (!in_valid_reg || advance)
        begin
            if (skid_valid_reg)
            begin
                in_byte_reg <= skid_byte_reg;
                in_last_reg <= skid_last_reg;
            end
            else
            begin
                in_byte_reg <= s_tdata;
                in_last_reg <= s_tlast;
            end
        end
        if (s_xfer)
        begin
            skid_byte_reg <= s_tdata;
            skid_last_reg <= s_tlast;
        end
    end

    hcle_parser #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (advance),
        .data_byte      (in_byte_reg),
        .end_of_message (in_last_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg.length_value;
    assign m_tuser = {out_reg.ended_at_blank_line, out_reg.length_found};

endmodule
